// ----- src/tkc_pkg.sv -----
package tkc_pkg;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REPLACE,
		CELL_SHIFT
	} tkc_op_t;

	typedef struct packed {
		logic gt;
		logic lt;
	} tkc_flags_t;

	localparam logic KIND_CUTOFF = 1'b0;
	localparam logic KIND_LIST   = 1'b1;

	localparam logic [5:0] KEEP_RESET = 6'd32;
	localparam logic       REG_KEEP   = 1'b0;

endpackage

// ----- src/tkc_cell.sv -----
module tkc_cell
	import tkc_pkg::*;
#(
	parameter int LEVEL_BITS = 32
) (
	input  logic                  clk,
	input  tkc_op_t               op,
	input  logic                  vld,
	input  logic [LEVEL_BITS-1:0] lvl,
	input  logic [LEVEL_BITS-1:0] left_val,
	input  tkc_flags_t            left_flags,
	input  logic [LEVEL_BITS-1:0] right_val,
	input  tkc_flags_t            right_flags,
	output logic [LEVEL_BITS-1:0] val,
	output tkc_flags_t            flags
);

	logic [LEVEL_BITS-1:0] val_q;
	logic [LEVEL_BITS-1:0] val_d;

	assign val      = val_q;
	assign flags.gt = !vld || (val_q > lvl);
	assign flags.lt = vld && (val_q < lvl);

	always_comb begin
		case (op)
			CELL_INSERT: begin
				if (flags.gt) begin
					val_d = left_flags.gt ? left_val : lvl;
				end else begin
					val_d = val_q;
				end
			end
			CELL_REPLACE: begin
				if (right_flags.lt) begin
					val_d = right_val;
				end else if (flags.lt) begin
					val_d = lvl;
				end else begin
					val_d = val_q;
				end
			end
			CELL_SHIFT: val_d = right_val;
			default:    val_d = val_q;
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

endmodule

// ----- src/streaming_top_k_cutoff_tracker_unit.sv -----
// An item that ends an interval, or the final item, moves the state to ST_CUT;
// the cutoff record is loaded into the single output register once that is free.
// After an item with no result s_tready stays high, else it is low until the
// cutoff record, and after the final item one list record per held level, are
// loaded; the sorted cell chain absorbs an item in its accept cycle. Reset clears
// fill, item and interval counts and sets keep_count to 32; cells are not reset.
module streaming_top_k_cutoff_tracker_unit
	import tkc_pkg::*;
#(
	parameter int CAPACITY   = 32,
	parameter int LEVEL_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] level
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [31:0] seen_count, [63:32] value
	output logic        m_tuser,   // [0] kind
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int FILL_W = $clog2(CAPACITY + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CUT,
		ST_LIST
	} state_t;

	state_t              st_q;
	logic [5:0]          keep_q;
	logic [FILL_W-1:0]   fill_q;
	logic [FILL_W-1:0]   intv_q;
	logic [31:0]         item_q;
	logic                fin_q;
	logic                m_tvalid_q;
	logic [63:0]         m_tdata_q;
	logic                m_tuser_q;
	logic                m_tlast_q;

	logic [FILL_W-1:0]   k_eff;
	logic [FILL_W-1:0]   intv_inc;
	logic                intv_hit;
	logic                accept;
	logic                slot_free;
	logic                emit;
	logic                do_insert;
	tkc_op_t             cell_op;
	logic [LEVEL_BITS-1:0] lvl_in;
	logic [LEVEL_BITS-1:0] cell_val [CAPACITY];
	tkc_flags_t          cell_flags [CAPACITY];
	logic [CAPACITY-1:0] cell_vld;

	assign pready   = 1'b1;
	assign prdata   = {26'd0, keep_q};
	assign s_tready = (st_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign slot_free = !m_tvalid_q || m_tready;
	assign emit     = slot_free && (st_q inside {ST_CUT, ST_LIST});
	assign lvl_in   = LEVEL_BITS'(s_tdata);

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	always_comb begin
		if (keep_q == '0) begin
			k_eff = FILL_W'(1);
		end else if (32'(keep_q) > 32'(CAPACITY)) begin
			k_eff = FILL_W'(CAPACITY);
		end else begin
			k_eff = FILL_W'(keep_q);
		end
	end

	assign intv_inc  = intv_q + FILL_W'(1);
	assign intv_hit  = (intv_inc >= k_eff);
	assign do_insert = (fill_q < k_eff);

	always_comb begin
		cell_op = CELL_HOLD;
		if (accept) begin
			if (do_insert) begin
				cell_op = CELL_INSERT;
			end else if (cell_flags[0].lt) begin
				cell_op = CELL_REPLACE;
			end
		end else if (st_q == ST_LIST && slot_free) begin
			cell_op = CELL_SHIFT;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign cell_vld[i] = (fill_q > FILL_W'(i));

		tkc_cell #(
			.LEVEL_BITS(LEVEL_BITS)
		) u_cell (
			.clk        (clk),
			.op         (cell_op),
			.vld        (cell_vld[i]),
			.lvl        (lvl_in),
			.left_val   ((i == 0) ? cell_val[i] : cell_val[(i == 0) ? 0 : i-1]),
			.left_flags ((i == 0) ? tkc_flags_t'(2'b00) : cell_flags[(i == 0) ? 0 : i-1]),
			.right_val  ((i == CAPACITY-1) ? cell_val[i]
				: cell_val[(i == CAPACITY-1) ? i : i+1]),
			.right_flags((i == CAPACITY-1) ? tkc_flags_t'(2'b00)
				: cell_flags[(i == CAPACITY-1) ? i : i+1]),
			.val        (cell_val[i]),
			.flags      (cell_flags[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= KEEP_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_KEEP) begin
			keep_q <= pwdata[5:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			fill_q     <= '0;
			intv_q     <= '0;
			item_q     <= '0;
			fin_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= 1'b0;
			m_tlast_q  <= 1'b0;
		end else begin
			if (emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						if (item_q != '1) begin
							item_q <= item_q + 32'd1;
						end
						if (do_insert) begin
							fill_q <= fill_q + FILL_W'(1);
						end
						intv_q <= intv_hit ? '0 : intv_inc;
						fin_q  <= s_tlast;
						st_q   <= (intv_hit || s_tlast) ? ST_CUT : ST_IDLE;
					end
				end
				ST_CUT: begin
					if (slot_free) begin
						m_tuser_q  <= KIND_CUTOFF;
						m_tdata_q  <= {32'(cell_val[0]), item_q};
						m_tlast_q  <= !fin_q;
						st_q       <= fin_q ? ST_LIST : ST_IDLE;
					end
				end
				ST_LIST: begin
					if (slot_free) begin
						m_tuser_q  <= KIND_LIST;
						m_tdata_q  <= {32'(cell_val[0]), 32'd0};
						m_tlast_q  <= (fill_q == FILL_W'(1));
						fill_q     <= fill_q - FILL_W'(1);
						if (fill_q == FILL_W'(1)) begin
							item_q <= '0;
							intv_q <= '0;
							st_q   <= ST_IDLE;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fill_q) <= 32'(CAPACITY))
		else $error("fill count exceeds capacity");

	a_list_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_LIST |-> fill_q != '0)
		else $error("list drain with empty store");

	a_list_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_LIST && fill_q > FILL_W'(1)) |-> cell_val[0] <= cell_val[1])
		else $error("cell chain out of order during drain");

	a_final_cutoff: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> st_q == ST_CUT)
		else $error("final beat did not start a cutoff record");

endmodule
